// ===== rtl/i2rd_pkg.sv =====
// Shared types, constants and helper functions for the radix digit converter.
package i2rd_pkg;

   localparam int VALUE_W   = 31;
   localparam int RADIX_W   = 6;
   localparam int CHAR_W    = 7;
   localparam int BIT_CNT_W = 5;
   localparam int CSR_DW    = 32;
   localparam int CSR_AW    = 3;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

   // Register index, taken from the word address bit of the register port.
   localparam logic REG_RADIX = 1'b0;

   localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 7'h30;
   localparam logic [CHAR_W-1:0]  CHAR_A       = 7'h41;
   localparam logic [RADIX_W-1:0] DEC_DIGIT_MAX = 6'd9;
   localparam logic [RADIX_W-1:0] ALPHA_OFFSET  = 6'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_LOAD,
      ST_SEND
   } state_type;

   // Codes below two act as binary, codes above thirty-six as base 36.
   function automatic logic [RADIX_W-1:0] radix_clamp(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] res;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end else begin
         res = r;
      end
      return res;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] res;
      if (d <= DEC_DIGIT_MAX) begin
         res = CHAR_ZERO + {1'b0, d};
      end else begin
         res = CHAR_A + {1'b0, d - ALPHA_OFFSET};
      end
      return res;
   endfunction

endpackage

// ===== rtl/integer_to_radix_digits_core.sv =====
// Integer to radix digit converter: bit-serial divider, digit store and output beat stage.
// The divider works out one digit per pass over the value bits and writes it to the store;
// the digits are then read back most significant first, each beat going through store read,
// load and send. An item holds the block until its final digit beat is taken, and no new
// input is taken meanwhile.
// Reset clears the sequencer, the digit count and the output valid, and loads radix 10;
// the digit store keeps its contents and needs no clearing.
module integer_to_radix_digits_core #(
   parameter int MAX_DIGITS = 31
) (
   input  logic                           clock,
   input  logic                           reset,
   // Input stream.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,   // [30:0] value, [31] zero fill
   // Digit stream.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // [6:0] digit_char, [7] zero fill
   output logic                           rsp_tlast,
   // Register port.
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [i2rd_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [i2rd_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [i2rd_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                           csr_pready
);
   import i2rd_pkg::*;

   // Store index and digit count widths follow the store depth.
   localparam int IW = $clog2(MAX_DIGITS);
   localparam int CW = $clog2(MAX_DIGITS + 1);

   // ------------------------------------------------------------------
   // Configuration register. The word address bit picks the register;
   // the byte offset bits are ignored.
   // ------------------------------------------------------------------
   logic [RADIX_W-1:0] radix_ff;
   logic [RADIX_W-1:0] radix_in;
   logic [RADIX_W-1:0] radix_eff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_RADIX);
   assign radix_in   = csr_wr ? csr_pwdata[RADIX_W-1:0] : radix_ff;
   assign csr_prdata = (csr_paddr[2] == REG_RADIX)
                       ? {{(CSR_DW-RADIX_W){1'b0}}, radix_ff} : '0;

   // The user must change the register only while the block is idle (the block
   // does not enforce this), so the clamped value can feed the divider directly.
   assign radix_eff = radix_clamp(radix_ff);

   // ------------------------------------------------------------------
   // Sequencer state and datapath registers.
   // ------------------------------------------------------------------
   state_type            state_ff, state_in;
   logic [VALUE_W-1:0]   q_ff, q_in;        // dividend shifting out, quotient shifting in
   logic [RADIX_W-1:0]   rem_ff, rem_in;    // partial remainder, always below the radix
   logic [BIT_CNT_W-1:0] bit_ff, bit_in;    // divider bit counter, counts down
   logic [CW-1:0]        cnt_ff, cnt_in;    // digits produced so far
   logic [IW-1:0]        rd_idx_ff, rd_idx_in;
   logic [RADIX_W-1:0]   rd_data_ff;
   logic [CHAR_W-1:0]    digit_ff, digit_in;
   logic                 last_ff, last_in;
   logic                 valid_ff, valid_in;

   logic [RADIX_W-1:0]   mem [MAX_DIGITS];

   // ------------------------------------------------------------------
   // Shared divider step: one restoring shift-and-subtract per cycle.
   // The shifted remainder needs one extra bit before the compare.
   // ------------------------------------------------------------------
   logic [RADIX_W:0]   rem_sh;
   logic [RADIX_W:0]   rem_sub;
   logic               ge;
   logic [RADIX_W-1:0] rem_nx;
   logic [VALUE_W-1:0] q_nx;
   logic               bit_last;
   logic               conv_done;

   assign rem_sh    = {rem_ff, q_ff[VALUE_W-1]};
   assign rem_sub   = rem_sh - {1'b0, radix_eff};
   assign ge        = rem_sh >= {1'b0, radix_eff};
   assign rem_nx    = ge ? rem_sub[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];
   assign q_nx      = {q_ff[VALUE_W-2:0], ge};
   assign bit_last  = (bit_ff == '0);
   // Conversion stops when the quotient runs out or the store is full; in
   // the latter case the higher digits are dropped.
   assign conv_done = (q_nx == '0) || (cnt_ff == CW'(MAX_DIGITS - 1));

   // ------------------------------------------------------------------
   // Next state.
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (bit_last && conv_done) state_in = ST_READ;
         end
         ST_READ: state_in = ST_LOAD;
         ST_LOAD: state_in = ST_SEND;
         ST_SEND: begin
            if (rsp_tready) state_in = last_ff ? ST_IDLE : ST_READ;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer outputs.
   // ------------------------------------------------------------------
   logic accept, div_step, digit_end, out_load, out_take;

   always_comb begin
      req_tready = 1'b0;
      div_step   = 1'b0;
      out_load   = 1'b0;
      out_take   = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_DIV:  div_step   = 1'b1;
         ST_LOAD: out_load   = 1'b1;
         ST_SEND: out_take   = rsp_tready;
         default: ;
      endcase
   end

   assign accept    = req_tvalid && req_tready;
   assign digit_end = div_step && bit_last;

   // ------------------------------------------------------------------
   // Datapath next values.
   // ------------------------------------------------------------------
   always_comb begin
      q_in      = q_ff;
      rem_in    = rem_ff;
      bit_in    = bit_ff;
      cnt_in    = cnt_ff;
      rd_idx_in = rd_idx_ff;
      digit_in  = digit_ff;
      last_in   = last_ff;
      valid_in  = valid_ff;
      if (accept) begin
         q_in   = req_tdata[VALUE_W-1:0];
         rem_in = '0;
         bit_in = BIT_CNT_W'(VALUE_W - 1);
         cnt_in = '0;
      end
      if (div_step) begin
         q_in   = q_nx;
         rem_in = bit_last ? '0 : rem_nx;
         bit_in = bit_last ? BIT_CNT_W'(VALUE_W - 1) : bit_ff - 1'b1;
      end
      if (digit_end) begin
         // The digit just written sits at cnt_ff; if it is the final one,
         // readback starts there with the most significant digit.
         cnt_in    = cnt_ff + 1'b1;
         rd_idx_in = cnt_ff[IW-1:0];
      end
      if (out_load) begin
         digit_in = digit_to_ascii(rd_data_ff);
         last_in  = (rd_idx_ff == '0);
         valid_in = 1'b1;
      end
      if (out_take) begin
         valid_in = 1'b0;
         if (!last_ff) rd_idx_in = rd_idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         radix_ff <= RADIX_RESET;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
         bit_ff   <= '0;
         q_ff     <= '0;
      end else begin
         state_ff <= state_in;
         radix_ff <= radix_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
         bit_ff   <= bit_in;
         q_ff     <= q_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      rd_idx_ff <= rd_idx_in;
      digit_ff  <= digit_in;
      last_ff   <= last_in;
   end

   // Digit store: remainders are written least significant first and read
   // back in reverse. Every read address was written earlier in the item.
   always_ff @(posedge clock) begin
      if (digit_end) mem[cnt_ff[IW-1:0]] <= rem_nx;
      rd_data_ff <= mem[rd_idx_ff];
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, digit_ff};
   assign rsp_tlast  = last_ff;

`ifndef SYNTH
   // A digit beat is only offered while the sequencer waits on the output.
   a_valid_in_send: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (state_ff == ST_SEND))
      else $error("digit beat offered outside the send state");

   // The divider keeps its partial remainder below the radix.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < radix_eff))
      else $error("partial remainder not below radix");

   // Once the final digit is taken, the block is ready for new input as soon as the sequencer is back in idle.
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("not ready after final digit beat");

   // Input is never taken while a digit beat is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while a digit beat is pending");
`endif

endmodule

// ===== verif/integer_to_radix_digits_core_tb.sv =====
// Self-checking testbench for the integer to radix digit converter core.
module integer_to_radix_digits_core_tb;
   import i2rd_pkg::*;

   // The core is built with its default store depth; 31 bits never need more
   // than 31 digits, so the store never overflows here.
   localparam int MAX_DIGITS = 31;

   // A directed row may spell its expected digits as an ASCII literal. The
   // literal is right-justified, so the lowest byte is the final digit.
   localparam int SPELL_W = 8*MAX_DIGITS;

   localparam int N_DIRECTED       = 22;
   localparam int N_RANDOM         = 110;
   localparam int PHASE_LEN        = N_RANDOM / 5;
   localparam int TAIL_START       = 88;
   localparam int LONG_HOLD_AT     = 200;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES     = 40;
   localparam int LIMIT_CYCLES     = 1_000_000;

   // The radix register is register zero; its byte address comes from the word bit.
   localparam logic [CSR_AW-1:0] RADIX_ADDR = {REG_RADIX, 2'b00};

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } digit_beat_type;

   typedef struct packed {
      logic [RADIX_W-1:0] code;
      logic [VALUE_W-1:0] value;
      logic [SPELL_W-1:0] spelled;  // zero means the predictor supplies the digits
   } directed_row_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [31:0]         req_tdata   = '0;   // [30:0] value, [31] zero fill
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [7:0]          rsp_tdata;          // [6:0] digit_char, [7] zero fill
   logic                rsp_tlast;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr   = '0;
   logic [CSR_DW-1:0]   csr_pwdata  = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   // Our own copy of the radix register, updated when a write completes.
   logic [RADIX_W-1:0]  radix_code = RADIX_RESET;

   // Digits still owed by the core, oldest first.
   digit_beat_type      pending_digits[$];

   int                  error_count = 0;
   int                  beats_seen  = 0;
   bit                  tail_phase  = 1'b0;

   // Directed stimulus. Rows whose digits are obvious carry them spelled out;
   // the rest fall back to the predictor.
   directed_row_type directed_rows [N_DIRECTED] = '{
      '{6'd10, 31'd0,          "0"},                               // zero right after reset
      '{6'd10, 31'h7FFFFFFF,   "2147483647"},                      // largest value
      '{6'd10, 31'd9,          "9"},
      '{6'd10, 31'd10,         "10"},
      '{6'd10, 31'd1234567890, '0},
      '{6'd2,  31'd0,          "0"},
      '{6'd2,  31'd1,          "1"},
      '{6'd2,  31'h7FFFFFFF,   "1111111111111111111111111111111"}, // all 31 digits
      '{6'd2,  31'h40000000,   "1000000000000000000000000000000"},
      '{6'd36, 31'd35,         "Z"},                               // top digit letter
      '{6'd36, 31'd36,         "10"},
      '{6'd36, 31'h7FFFFFFF,   "ZIK0ZJ"},
      '{6'd16, 31'h7FFFFFFF,   "7FFFFFFF"},
      '{6'd16, 31'hABCDEF,     "ABCDEF"},
      '{6'd1,  31'd5,          "101"},                             // radix one acts as two
      '{6'd0,  31'd6,          "110"},                             // radix zero acts as two
      '{6'd37, 31'd71,         "1Z"},                              // above 36 acts as 36
      '{6'd63, 31'd1295,       "ZZ"},
      '{6'd8,  31'd511,        "777"},
      '{6'd3,  31'h7FFFFFFF,   '0},
      '{6'd7,  31'd123456789,  '0},
      '{6'd10, 31'd1000000000, "1000000000"}
   };

   integer_to_radix_digits_core #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // Divides the value down by the effective radix, keeping remainders least
   // significant first, then queues them back most significant first.
   function automatic void predict_digits(input logic [VALUE_W-1:0] value);
      int unsigned    base;
      int unsigned    quotient;
      int unsigned    rems[MAX_DIGITS];
      int             n;
      int             idx;
      digit_beat_type beat;
      if (radix_code < RADIX_MIN) begin
         base = 32'(RADIX_MIN);
      end else if (radix_code > RADIX_MAX) begin
         base = 32'(RADIX_MAX);
      end else begin
         base = 32'(radix_code);
      end
      quotient = 32'(value);
      n = 0;
      do begin
         rems[n] = quotient % base;
         n++;
         quotient = quotient / base;
      end while (quotient != 0 && n < MAX_DIGITS);
      for (int k = 0; k < n; k++) begin
         idx = n - 1 - k;
         if (rems[idx] <= 32'(DEC_DIGIT_MAX)) begin
            beat.ch = CHAR_ZERO + CHAR_W'(rems[idx]);
         end else begin
            beat.ch = CHAR_A + CHAR_W'(rems[idx] - 32'(ALPHA_OFFSET));
         end
         beat.last = (idx == 0);
         pending_digits.push_back(beat);
      end
   endfunction

   function automatic logic [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] v;
      v = VALUE_W'($urandom);
      case ($urandom_range(0, 3))
         0: v = v;
         1: v = v >> $urandom_range(0, VALUE_W-1);   // spread over all digit counts
         2: v = VALUE_W'($urandom_range(0, 40));     // small values, up to 40
         default: v = {VALUE_W{1'b1}} - VALUE_W'($urandom_range(0, 3));
      endcase
      return v;
   endfunction

   // Offers one value and waits for the core to take it. The expected digits
   // are queued at the accepting edge, using the radix in force at that time.
   task automatic offer_value(input logic [VALUE_W-1:0] value,
                              input logic [SPELL_W-1:0] spelled);
      digit_beat_type beat;
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, value};
      do @(posedge clock); while (!req_tready);
      if (spelled != '0) begin
         for (int i = MAX_DIGITS-1; i >= 0; i--) begin
            if (spelled[8*i +: 8] != 8'd0) begin
               beat.ch   = spelled[8*i +: CHAR_W];
               beat.last = (i == 0);
               pending_digits.push_back(beat);
            end
         end
      end else begin
         predict_digits(value);
      end
   endtask

   // Random idle burst on the input side. Valid stays high when no gap is
   // taken, so back-to-back items see no dropout.
   task automatic sender_gap();
      if (!tail_phase && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom & 32'h7FFF_FFFF;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Changes the radix only once the core has delivered every digit owed.
   // Every value yields at least one digit, so an empty queue means idle.
   // The write is followed by a read-back of the register.
   task automatic change_radix(input logic [RADIX_W-1:0] code);
      req_tvalid <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= RADIX_ADDR;
      csr_pwdata  <= {(CSR_DW-RADIX_W)'($urandom), code};  // upper bits are ignored
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      radix_code  = code;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DW'(code)) begin
         $display("[%0t] radix read-back mismatch: expected %0d, got %0d",
                  $time, code, csr_prdata);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Main stimulus: reset, the directed table, then random phases at
   // several radix settings, the last stretch of them without idling.
   initial begin : stimulus
      logic [RADIX_W-1:0] phase_codes[5];
      int                 item;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int row = 0; row < N_DIRECTED; row++) begin
         if (directed_rows[row].code != radix_code) begin
            change_radix(directed_rows[row].code);
         end
         offer_value(directed_rows[row].value, directed_rows[row].spelled);
         sender_gap();
      end

      // Binary and base 36 bound the work per item; then one phase picks any code,
      // out-of-range ones included, one an in-range code, and the last the top code.
      phase_codes[0] = RADIX_W'(2);
      phase_codes[1] = RADIX_W'(36);
      phase_codes[2] = RADIX_W'($urandom_range(0, 63));
      phase_codes[3] = RADIX_W'($urandom_range(3, 35));
      phase_codes[4] = RADIX_W'(63);
      item = 0;
      for (int phase = 0; phase < 5; phase++) begin
         change_radix(phase_codes[phase]);
         for (int i = 0; i < PHASE_LEN; i++) begin
            if (item >= TAIL_START) tail_phase = 1'b1;
            offer_value(random_value(), '0);
            sender_gap();
            item++;
         end
      end

      req_tvalid <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Digit sink. Random short stalls, plus one long hold-off after some
   // traffic so the core backs up and refuses input for a while.
   initial begin : digit_sink
      bit long_hold_done;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && beats_seen >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Each accepted digit beat is matched against the oldest owed digit.
   always @(posedge clock) begin : digit_check
      digit_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_seen++;
         if (pending_digits.size() == 0) begin
            $display("[%0t] unexpected digit beat: got char %h last %b",
                     $time, rsp_tdata[CHAR_W-1:0], rsp_tlast);
            error_count++;
         end else begin
            want = pending_digits.pop_front();
            if (rsp_tdata[CHAR_W-1:0] !== want.ch) begin
               $display("[%0t] digit char mismatch: expected %h, got %h",
                        $time, want.ch, rsp_tdata[CHAR_W-1:0]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("[%0t] last flag mismatch: expected %b, got %b",
                        $time, want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Watchdog, several times the slowest legal run.
   initial begin : watchdog
      #(4*LIMIT_CYCLES);
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== integer_to_radix_digits_core.f =====
rtl/i2rd_pkg.sv
rtl/integer_to_radix_digits_core.sv
verif/integer_to_radix_digits_core_tb.sv
